// ----- rtl/psp_pkg.sv -----
// Shared types, widths, register codes and helpers of the pair source position generator.
package psp_pkg;

	// Field widths
	localparam int MOM_W  = 24;
	localparam int RAND_W = 16;
	localparam int POS_W  = 32;
	localparam int REG_W  = 16;

	// Register index codes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_OUT_SIGMA  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OUT_MEAN   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SIDE_MULT  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LONG_MULT  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_TIME_MULT  = 3'd4;

	// Fixed-point shifts
	localparam int MEAN_SHIFT = 12;
	localparam int ROUT_SHIFT = 4;
	localparam int RAD_SHIFT  = 12;
	localparam int PT_SHIFT   = 14;
	localparam int DIR_SHIFT  = 31;
	localparam int DIR_FRAC   = 24;

	// Pair momentum and its square
	localparam int SUM_W  = MOM_W + 1;
	localparam int SQP_W  = 2 * SUM_W;
	localparam int SQ_W   = 2 * MOM_W + 1;
	localparam int PP_W   = SQ_W + 1;
	localparam int V_W    = PP_W + PT_SHIFT;
	localparam int ROOT_W = V_W / 2;
	localparam int SREM_W = ROOT_W + 3;

	// Direction divider
	localparam int QUO_W  = MOM_W + 1;
	localparam int NUM_W  = MOM_W + 2 + DIR_SHIFT;
	localparam int DEN_W  = ROOT_W + 1;
	localparam int DREM_W = DEN_W + 1;
	localparam int U_W    = QUO_W + 1;

	// Radii and products
	localparam int CPROD_W    = 2 * REG_W;
	localparam int MO_W       = REG_W + RAND_W;
	localparam int ROUT_SUM_W = MO_W + 2;
	localparam int ROUT_W     = ROUT_SUM_W - ROUT_SHIFT;
	localparam int MSIDE_W    = CPROD_W + RAND_W;
	localparam int RSUM_W     = MSIDE_W + 1;
	localparam int RSIDE_W    = RSUM_W - RAD_SHIFT;
	localparam int XP_W       = ROUT_W + U_W;
	localparam int YP_W       = RSIDE_W + U_W;
	localparam int XS_W       = YP_W + 2;
	localparam int SAT_IN_W   = 64;

	// Data that rides along the square root and divider pipelines
	typedef struct packed {
		logic signed [SUM_W-1:0]   px;
		logic signed [SUM_W-1:0]   py;
		logic                      zero_pt;
		logic signed [ROUT_W-1:0]  rout;
		logic signed [RSIDE_W-1:0] rside;
		logic signed [POS_W-1:0]   pz;
		logic signed [POS_W-1:0]   pt;
	} side_t;

	// Clip a wide signed value to the position range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = {{(SAT_IN_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return hi[POS_W-1:0];
		else if (v < lo)
			return lo[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

endpackage

// ----- rtl/pair_source_position_generator.sv -----
// Top level of the pair source position generator.
// Takes one particle pair per clock while the output is not stalled and returns one emission point per pair, in order.
// Each accepted input beat passes through three front stages
// (momentum sums and radius products, squares and radii, pt squared), a 32-stage square root,
// one setup stage, a 25-stage direction divider, then sign, rotation product and output stages.
// The whole pipeline advances whenever the output register is empty or being taken.
// Registers are written through cfg_wr_en, cfg_addr and cfg_wdata;
// write them only while the pipeline is empty.
module pair_source_position_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [psp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [psp_pkg::REG_W-1:0]             cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [psp_pkg::MOM_W-1:0]      first_mom_x,
	input  logic signed [psp_pkg::MOM_W-1:0]      first_mom_y,
	input  logic signed [psp_pkg::MOM_W-1:0]      second_mom_x,
	input  logic signed [psp_pkg::MOM_W-1:0]      second_mom_y,
	input  logic signed [psp_pkg::RAND_W-1:0]     rand_out,
	input  logic signed [psp_pkg::RAND_W-1:0]     rand_side,
	input  logic signed [psp_pkg::RAND_W-1:0]     rand_long,
	input  logic signed [psp_pkg::RAND_W-1:0]     rand_time,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [psp_pkg::POS_W-1:0]      pos_x,
	output logic signed [psp_pkg::POS_W-1:0]      pos_y,
	output logic signed [psp_pkg::POS_W-1:0]      pos_z,
	output logic signed [psp_pkg::POS_W-1:0]      pos_t,
	output logic                                  zero_pt_flag
);
	localparam int SUM_W      = psp_pkg::SUM_W;
	localparam int SQP_W      = psp_pkg::SQP_W;
	localparam int SQ_W       = psp_pkg::SQ_W;
	localparam int PP_W       = psp_pkg::PP_W;
	localparam int V_W        = psp_pkg::V_W;
	localparam int ROOT_W     = psp_pkg::ROOT_W;
	localparam int NUM_W      = psp_pkg::NUM_W;
	localparam int DEN_W      = psp_pkg::DEN_W;
	localparam int QUO_W      = psp_pkg::QUO_W;
	localparam int U_W        = psp_pkg::U_W;
	localparam int REG_W      = psp_pkg::REG_W;
	localparam int CPROD_W    = psp_pkg::CPROD_W;
	localparam int MO_W       = psp_pkg::MO_W;
	localparam int ROUT_SUM_W = psp_pkg::ROUT_SUM_W;
	localparam int ROUT_W     = psp_pkg::ROUT_W;
	localparam int MSIDE_W    = psp_pkg::MSIDE_W;
	localparam int RSUM_W     = psp_pkg::RSUM_W;
	localparam int RSIDE_W    = psp_pkg::RSIDE_W;
	localparam int XP_W       = psp_pkg::XP_W;
	localparam int YP_W       = psp_pkg::YP_W;
	localparam int XS_W       = psp_pkg::XS_W;
	localparam int SAT_IN_W   = psp_pkg::SAT_IN_W;
	localparam int POS_W      = psp_pkg::POS_W;
	localparam int MEAN_SHIFT = psp_pkg::MEAN_SHIFT;
	localparam int ROUT_SHIFT = psp_pkg::ROUT_SHIFT;
	localparam int RAD_SHIFT  = psp_pkg::RAD_SHIFT;
	localparam int PT_SHIFT   = psp_pkg::PT_SHIFT;
	localparam int DIR_SHIFT  = psp_pkg::DIR_SHIFT;
	localparam int DIR_FRAC   = psp_pkg::DIR_FRAC;

	logic adv;

	// Configuration registers and their sigma products
	logic signed [REG_W-1:0]   out_sigma_q;
	logic signed [REG_W-1:0]   out_mean_q;
	logic signed [REG_W-1:0]   side_mult_q;
	logic signed [REG_W-1:0]   long_mult_q;
	logic signed [REG_W-1:0]   time_mult_q;
	logic signed [CPROD_W-1:0] side_prod_q;
	logic signed [CPROD_W-1:0] long_prod_q;
	logic signed [CPROD_W-1:0] time_prod_q;

	// Front stages
	logic                       valid_s1;
	logic signed [SUM_W-1:0]    px_s1, py_s1;
	logic signed [MO_W-1:0]     mo_s1;
	logic signed [MSIDE_W-1:0]  ms_s1, mz_s1, mt_s1;

	logic signed [ROUT_SUM_W-1:0] rout_sum;
	logic signed [RSUM_W-1:0]     rside_sum, z_sum, t_sum;

	logic                       valid_s2;
	logic signed [SUM_W-1:0]    px_s2, py_s2;
	logic signed [SQP_W-1:0]    sqx_s2, sqy_s2;
	logic signed [ROUT_W-1:0]   rout_s2;
	logic signed [RSIDE_W-1:0]  rside_s2;
	logic signed [POS_W-1:0]    z_s2, t_s2;

	logic [PP_W-1:0]            pp;
	logic                       valid_s3;
	psp_pkg::side_t             side_s3;
	logic [PP_W-1:0]            pp_s3;

	// Square root output and divider setup
	logic                       sq_valid;
	psp_pkg::side_t             sq_side;
	logic [ROOT_W-1:0]          sq_root;
	logic [SUM_W-1:0]           mag_x, mag_y;

	logic                       valid_s4;
	psp_pkg::side_t             side_s4;
	logic [NUM_W-1:0]           numx_s4, numy_s4;
	logic [DEN_W-1:0]           den_s4;

	logic                       dv_valid;
	psp_pkg::side_t             dv_side;
	logic [QUO_W-1:0]           dv_qx, dv_qy;

	// Back stages
	logic                       valid_s5;
	psp_pkg::side_t             side_s5;
	logic signed [U_W-1:0]      ux_s5, uy_s5;

	logic                       valid_s6;
	logic                       zero_s6;
	logic signed [POS_W-1:0]    z_s6, t_s6;
	logic signed [XP_W-1:0]     ox_s6, oy_s6;
	logic signed [YP_W-1:0]     sx_s6, sy_s6;

	logic signed [XS_W-1:0]     x_sum, y_sum;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_sigma_q <= '0;
			out_mean_q  <= '0;
			side_mult_q <= '0;
			long_mult_q <= '0;
			time_mult_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				psp_pkg::REG_OUT_SIGMA: out_sigma_q <= cfg_wdata;
				psp_pkg::REG_OUT_MEAN:  out_mean_q  <= cfg_wdata;
				psp_pkg::REG_SIDE_MULT: side_mult_q <= cfg_wdata;
				psp_pkg::REG_LONG_MULT: long_mult_q <= cfg_wdata;
				psp_pkg::REG_TIME_MULT: time_mult_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sigma times multiplier, refreshed every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_prod_q <= '0;
			long_prod_q <= '0;
			time_prod_q <= '0;
		end else begin
			side_prod_q <= out_sigma_q * side_mult_q;
			long_prod_q <= out_sigma_q * long_mult_q;
			time_prod_q <= out_sigma_q * time_mult_q;
		end
	end

	// Valid bits of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= sq_valid;
			valid_s5  <= dv_valid;
			valid_s6  <= valid_s5;
			out_valid <= valid_s6;
		end
	end

	// Stage 1: momentum sums and radius products
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= SUM_W'(first_mom_x) + SUM_W'(second_mom_x);
			py_s1 <= SUM_W'(first_mom_y) + SUM_W'(second_mom_y);
			mo_s1 <= out_sigma_q * rand_out;
			ms_s1 <= side_prod_q * rand_side;
			mz_s1 <= long_prod_q * rand_long;
			mt_s1 <= time_prod_q * rand_time;
		end
	end

	// Round the radii, z and t
	always_comb begin
		rout_sum  = ROUT_SUM_W'(mo_s1) + (ROUT_SUM_W'(out_mean_q) <<< MEAN_SHIFT)
			+ ROUT_SUM_W'(1 << (ROUT_SHIFT - 1));
		rside_sum = RSUM_W'(ms_s1) + RSUM_W'(1 << (RAD_SHIFT - 1));
		z_sum     = RSUM_W'(mz_s1) + RSUM_W'(1 << (RAD_SHIFT - 1));
		t_sum     = RSUM_W'(mt_s1) + RSUM_W'(1 << (RAD_SHIFT - 1));
	end

	// Stage 2: momentum squares, rounded radii
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			sqx_s2   <= px_s1 * px_s1;
			sqy_s2   <= py_s1 * py_s1;
			rout_s2  <= rout_sum[ROUT_SUM_W-1:ROUT_SHIFT];
			rside_s2 <= rside_sum[RSUM_W-1:RAD_SHIFT];
			z_s2     <= psp_pkg::sat_pos(SAT_IN_W'(z_sum >>> RAD_SHIFT));
			t_s2     <= psp_pkg::sat_pos(SAT_IN_W'(t_sum >>> RAD_SHIFT));
		end
	end

	assign pp = PP_W'(sqx_s2[SQ_W-1:0]) + PP_W'(sqy_s2[SQ_W-1:0]);

	// Stage 3: pt squared and zero check
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s3         <= pp;
			side_s3.px    <= px_s2;
			side_s3.py    <= py_s2;
			side_s3.zero_pt <= (pp == '0);
			side_s3.rout  <= rout_s2;
			side_s3.rside <= rside_s2;
			side_s3.pz    <= z_s2;
			side_s3.pt    <= t_s2;
		end
	end

	psp_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s3),
		.in_side   (side_s3),
		.in_val    ({pp_s3, {PT_SHIFT{1'b0}}}),
		.out_valid (sq_valid),
		.out_side  (sq_side),
		.out_root  (sq_root)
	);

	// Magnitudes for the divider
	always_comb begin
		mag_x = sq_side.px[SUM_W-1] ? SUM_W'(-sq_side.px) : SUM_W'(sq_side.px);
		mag_y = sq_side.py[SUM_W-1] ? SUM_W'(-sq_side.py) : SUM_W'(sq_side.py);
	end

	// Stage 4: rounded division setup, num = 2*|p|*2^31 + pt, den = 2*pt
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= sq_side;
			numx_s4 <= NUM_W'({mag_x, {(DIR_SHIFT + 1){1'b0}}}) + NUM_W'(sq_root);
			numy_s4 <= NUM_W'({mag_y, {(DIR_SHIFT + 1){1'b0}}}) + NUM_W'(sq_root);
			den_s4  <= {sq_root, 1'b0};
		end
	end

	psp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s4),
		.in_side   (side_s4),
		.num_x     (numx_s4),
		.num_y     (numy_s4),
		.den       (den_s4),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.quo_x     (dv_qx),
		.quo_y     (dv_qy)
	);

	// Stage 5: restore the direction signs
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= dv_side;
			ux_s5   <= dv_side.px[SUM_W-1] ? -U_W'(dv_qx) : U_W'(dv_qx);
			uy_s5   <= dv_side.py[SUM_W-1] ? -U_W'(dv_qy) : U_W'(dv_qy);
		end
	end

	// Stage 6: rotation products
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s6 <= side_s5.zero_pt;
			z_s6    <= side_s5.pz;
			t_s6    <= side_s5.pt;
			ox_s6   <= side_s5.rout * ux_s5;
			oy_s6   <= side_s5.rout * uy_s5;
			sx_s6   <= side_s5.rside * ux_s5;
			sy_s6   <= side_s5.rside * uy_s5;
		end
	end

	always_comb begin
		x_sum = XS_W'(ox_s6) - XS_W'(sy_s6) + XS_W'(1 << (DIR_FRAC - 1));
		y_sum = XS_W'(oy_s6) + XS_W'(sx_s6) + XS_W'(1 << (DIR_FRAC - 1));
	end

	// Output register: round, saturate, force x and y to zero without pt
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_pt_flag <= zero_s6;
			pos_z        <= z_s6;
			pos_t        <= t_s6;
			if (zero_s6) begin
				pos_x <= '0;
				pos_y <= '0;
			end else begin
				pos_x <= psp_pkg::sat_pos(SAT_IN_W'(x_sum >>> DIR_FRAC));
				pos_y <= psp_pkg::sat_pos(SAT_IN_W'(y_sum >>> DIR_FRAC));
			end
		end
	end

`ifndef ASSERT_OFF
	a_zero_pt_xy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_pt_flag |-> pos_x == '0 && pos_y == '0)
		else $error("x or y nonzero on a zero pt beat");

	a_cfg_sigma: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && cfg_addr == psp_pkg::REG_OUT_SIGMA |=> out_sigma_q == $past(cfg_wdata))
		else $error("out sigma write lost");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && valid_s6 |=> valid_s6 && $stable(ox_s6) && $stable(sy_s6))
		else $error("rotation stage moved during a stall");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_z) && $stable(zero_pt_flag))
		else $error("output beat changed while stalled");
`endif

endmodule

// ----- rtl/psp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module psp_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  psp_pkg::side_t                in_side,
	input  logic [psp_pkg::V_W-1:0]       in_val,
	output logic                          out_valid,
	output psp_pkg::side_t                out_side,
	output logic [psp_pkg::ROOT_W-1:0]    out_root
);
	localparam int V_W    = psp_pkg::V_W;
	localparam int ROOT_W = psp_pkg::ROOT_W;
	localparam int SREM_W = psp_pkg::SREM_W;

	logic                   valid_s [1:ROOT_W];
	psp_pkg::side_t         side_s  [1:ROOT_W];
	logic [V_W-1:0]         val_s   [1:ROOT_W];
	logic [SREM_W-3:0]      rem_s   [1:ROOT_W];
	logic [ROOT_W-1:0]      root_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic                 cur_valid;
		psp_pkg::side_t       cur_side;
		logic [V_W-1:0]       cur_val;
		logic [SREM_W-3:0]    cur_rem;
		logic [ROOT_W-1:0]    cur_root;
		logic [SREM_W-1:0]    rem_sh;
		logic [SREM_W-1:0]    trial;
		logic [SREM_W-1:0]    diff;
		logic                 take;

		if (k == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_side  = in_side;
			assign cur_val   = in_val;
			assign cur_rem   = '0;
			assign cur_root  = '0;
		end else begin : g_next
			assign cur_valid = valid_s[k];
			assign cur_side  = side_s[k];
			assign cur_val   = val_s[k];
			assign cur_rem   = rem_s[k];
			assign cur_root  = root_s[k];
		end

		// Bring down two radicand bits and try the next root bit
		always_comb begin
			rem_sh = {cur_rem, cur_val[V_W-1 -: 2]};
			trial  = {1'b0, cur_root, 2'b01};
			diff   = rem_sh - trial;
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= cur_side;
				val_s[k+1]  <= cur_val << 2;
				if (take) begin
					rem_s[k+1]  <= diff[SREM_W-3:0];
					root_s[k+1] <= {cur_root[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rem_sh[SREM_W-3:0];
					root_s[k+1] <= {cur_root[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];

endmodule

// ----- rtl/psp_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
module psp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  psp_pkg::side_t                in_side,
	input  logic [psp_pkg::NUM_W-1:0]     num_x,
	input  logic [psp_pkg::NUM_W-1:0]     num_y,
	input  logic [psp_pkg::DEN_W-1:0]     den,
	output logic                          out_valid,
	output psp_pkg::side_t                out_side,
	output logic [psp_pkg::QUO_W-1:0]     quo_x,
	output logic [psp_pkg::QUO_W-1:0]     quo_y
);
	localparam int NUM_W  = psp_pkg::NUM_W;
	localparam int QUO_W  = psp_pkg::QUO_W;
	localparam int DEN_W  = psp_pkg::DEN_W;
	localparam int DREM_W = psp_pkg::DREM_W;

	logic                 valid_s [1:QUO_W];
	psp_pkg::side_t       side_s  [1:QUO_W];
	logic [DEN_W-1:0]     den_s   [1:QUO_W];
	logic [DEN_W-1:0]     rem_s   [1:QUO_W][0:1];
	logic [QUO_W-1:0]     low_s   [1:QUO_W][0:1];
	logic [QUO_W-1:0]     quo_s   [1:QUO_W][0:1];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic                 cur_valid;
		psp_pkg::side_t       cur_side;
		logic [DEN_W-1:0]     cur_den;
		logic [DEN_W-1:0]     cur_rem [0:1];
		logic [QUO_W-1:0]     cur_low [0:1];
		logic [QUO_W-1:0]     cur_quo [0:1];
		logic [DREM_W-1:0]    rem_sh  [0:1];
		logic [DREM_W-1:0]    diff    [0:1];
		logic [DEN_W-1:0]     rem_nx  [0:1];
		logic [QUO_W-1:0]     quo_nx  [0:1];

		if (k == 0) begin : g_first
			assign cur_valid  = in_valid;
			assign cur_side   = in_side;
			assign cur_den    = den;
			assign cur_rem[0] = DEN_W'(num_x[NUM_W-1:QUO_W]);
			assign cur_rem[1] = DEN_W'(num_y[NUM_W-1:QUO_W]);
			assign cur_low[0] = num_x[QUO_W-1:0];
			assign cur_low[1] = num_y[QUO_W-1:0];
			assign cur_quo[0] = '0;
			assign cur_quo[1] = '0;
		end else begin : g_next
			assign cur_valid  = valid_s[k];
			assign cur_side   = side_s[k];
			assign cur_den    = den_s[k];
			assign cur_rem[0] = rem_s[k][0];
			assign cur_rem[1] = rem_s[k][1];
			assign cur_low[0] = low_s[k][0];
			assign cur_low[1] = low_s[k][1];
			assign cur_quo[0] = quo_s[k][0];
			assign cur_quo[1] = quo_s[k][1];
		end

		// Shift in the next dividend bit and subtract where it fits
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				rem_sh[l] = {cur_rem[l], cur_low[l][QUO_W-1]};
				diff[l]   = rem_sh[l] - {1'b0, cur_den};
				if (rem_sh[l] >= {1'b0, cur_den}) begin
					rem_nx[l] = diff[l][DEN_W-1:0];
					quo_nx[l] = {cur_quo[l][QUO_W-2:0], 1'b1};
				end else begin
					rem_nx[l] = rem_sh[l][DEN_W-1:0];
					quo_nx[l] = {cur_quo[l][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= cur_side;
				den_s[k+1]  <= cur_den;
				for (int l = 0; l < 2; l++) begin
					rem_s[k+1][l] <= rem_nx[l];
					low_s[k+1][l] <= cur_low[l] << 1;
					quo_s[k+1][l] <= quo_nx[l];
				end
			end
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign out_side  = side_s[QUO_W];
	assign quo_x     = quo_s[QUO_W][0];
	assign quo_y     = quo_s[QUO_W][1];

endmodule
